// ===== rtl/aarm_pkg.sv =====
package aarm_pkg;

  // default build parameters
  localparam int CORDIC_STEPS_DEF    = 16;
  localparam int COMPONENT_WIDTH_DEF = 16;

  // binary angle input width
  localparam int ANGLE_W = 16;

  // CORDIC datapath: Q4.30 for x/y, 2^32 units per turn for z
  localparam int CW = 34;
  localparam logic signed [CW-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;
  localparam logic signed [CW-1:0] ONE_Q30         = 34'sd1073741824;

  // unit length in Q2.14 and one in Q4.12
  localparam logic [15:0] UNIT_Q14 = 16'd16384;
  localparam int          ONE_Q12  = 4096;

  // atan(2^-k) in turns scaled by 2^32
  localparam int ATAN_COUNT = 24;
  localparam logic [31:0] ATAN_TURN32 [ATAN_COUNT] = '{
    32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2E, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
    32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
    32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
  };

endpackage

// ===== rtl/aarm_in_if.sv =====
interface aarm_in_if #(
  parameter int W = aarm_pkg::COMPONENT_WIDTH_DEF
);
  import aarm_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [W-1:0]       axis_x;
  logic signed [W-1:0]       axis_y;
  logic signed [W-1:0]       axis_z;
  logic        [ANGLE_W-1:0] turn_angle;

  modport source (output valid, axis_x, axis_y, axis_z, turn_angle, input ready);
  modport sink   (input valid, axis_x, axis_y, axis_z, turn_angle, output ready);

endinterface

// ===== rtl/aarm_out_if.sv =====
interface aarm_out_if #(
  parameter int W = aarm_pkg::COMPONENT_WIDTH_DEF
);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] e_r0c0;
  logic signed [W-1:0] e_r0c1;
  logic signed [W-1:0] e_r0c2;
  logic signed [W-1:0] e_r1c0;
  logic signed [W-1:0] e_r1c1;
  logic signed [W-1:0] e_r1c2;
  logic signed [W-1:0] e_r2c0;
  logic signed [W-1:0] e_r2c1;
  logic signed [W-1:0] e_r2c2;

  modport source (output valid, e_r0c0, e_r0c1, e_r0c2, e_r1c0, e_r1c1, e_r1c2,
                  e_r2c0, e_r2c1, e_r2c2, input ready);
  modport sink   (input valid, e_r0c0, e_r0c1, e_r0c2, e_r1c0, e_r1c1, e_r1c2,
                  e_r2c0, e_r2c1, e_r2c2, output ready);

endinterface

// ===== rtl/aarm_cordic.sv =====
module aarm_cordic #(
  parameter int STEPS = aarm_pkg::CORDIC_STEPS_DEF
) (
  input  logic                           clk_i,
  input  logic [STEPS-1:0]               en_i,
  input  logic signed [aarm_pkg::CW-1:0] z_i,
  output logic signed [aarm_pkg::CW-1:0] cos_o,
  output logic signed [aarm_pkg::CW-1:0] sin_o
);
  import aarm_pkg::*;

  logic signed [CW-1:0] x_q [STEPS];
  logic signed [CW-1:0] y_q [STEPS];
  logic signed [CW-1:0] z_q [STEPS];

  // one rotation per stage, registered
  for (genvar j = 0; j < STEPS; j++) begin : g_step
    logic signed [CW-1:0] x_in, y_in, z_in;
    logic signed [CW-1:0] x_d, y_d, z_d;
    logic signed [CW-1:0] atan;

    if (j == 0) begin : g_first
      assign x_in = CORDIC_GAIN_Q30;
      assign y_in = '0;
      assign z_in = z_i;
    end else begin : g_next
      assign x_in = x_q[j-1];
      assign y_in = y_q[j-1];
      assign z_in = z_q[j-1];
    end

    assign atan = $signed({2'b00, ATAN_TURN32[j]});

    always_comb begin
      if (!z_in[CW-1]) begin
        x_d = x_in - (y_in >>> j);
        y_d = y_in + (x_in >>> j);
        z_d = z_in - atan;
      end else begin
        x_d = x_in + (y_in >>> j);
        y_d = y_in - (x_in >>> j);
        z_d = z_in + atan;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i[j]) begin
        x_q[j] <= x_d;
        y_q[j] <= y_d;
        z_q[j] <= z_d;
      end
    end
  end

  assign cos_o = x_q[STEPS-1];
  assign sin_o = y_q[STEPS-1];

endmodule

// ===== rtl/axis_angle_rotation_matrix.sv =====
// Axis-angle to rotation matrix, Q2.14 output.
// in_i  (sink): axis_x/y/z signed Q4.12 (any length, all zero means +z)
//               and turn_angle, 65536 units per turn. Taken when valid && ready.
// out_o (source): the nine upper 3x3 entries, rounded and saturated,
//               one result item for every input item, in order.
// cfg_we_i/cfg_data_i: keep_angle_sense; 0 negates the angle. Write only
//               while no item is in flight.
// Throughput: one item per cycle while out_o.ready is high. The depth is set
// by the square root (one result bit per stage, 31 stages) followed by the
// divider (one quotient bit per stage, 16 stages); the sin/cos CORDIC runs
// alongside the square root, one rotation per stage. Each stage has its own
// valid bit and advances when it is empty or the next stage advances, so a
// stalled output only backs up full stages; bubbles are squeezed out and
// in_i.ready stays high while any stage is empty.
// Reset clears all valid bits and sets keep_angle_sense to 0.
module axis_angle_rotation_matrix #(
  parameter int CORDIC_STEPS    = aarm_pkg::CORDIC_STEPS_DEF,
  parameter int COMPONENT_WIDTH = aarm_pkg::COMPONENT_WIDTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  aarm_in_if.sink           in_i,
  aarm_out_if.source        out_o,
  input  logic              cfg_we_i,
  input  logic              cfg_data_i
);
  import aarm_pkg::*;

  localparam int W = COMPONENT_WIDTH;

  // stage map
  localparam int ST_IN      = 0;
  localparam int ST_NORM    = 1;
  localparam int ST_SQ      = 2;
  localparam int ST_SUM     = 3;
  localparam int ST_RT0     = 4;
  localparam int ST_RT_LAST = 34;
  localparam int ST_NUM     = 35;
  localparam int ST_DV0     = 36;
  localparam int ST_DV_LAST = 51;
  localparam int ST_U       = 52;
  localparam int ST_P1      = 53;
  localparam int ST_P2      = 54;
  localparam int ST_OUT     = 55;
  localparam int NST        = 56;
  localparam int ST_CS      = ST_RT0 + CORDIC_STEPS;

  localparam logic signed [63:0] RND_HALF = 64'sd1 <<< 43;
  localparam logic signed [63:0] SAT_HI   = (64'sd1 <<< (W-1)) - 64'sd1;
  localparam logic signed [63:0] SAT_LO   = -(64'sd1 <<< (W-1));

  typedef struct {
    logic [2:0]           neg;
    logic [W:0]           mag [3];
    logic [14:0]          m [3];
    logic [29:0]          sq [3];
    logic [61:0]          v;
    logic [61:0]          res;
    logic [43:0]          rem [3];
    logic [15:0]          q [3];
    logic signed [CW-1:0] z;
    logic signed [CW-1:0] c;
    logic signed [CW-1:0] s;
    logic signed [CW-1:0] t;
    logic                 flip;
    logic signed [15:0]   u [3];
    logic signed [31:0]   pr [6];
    logic signed [63:0]   tp [6];
    logic signed [63:0]   sp [3];
    logic signed [63:0]   ct;
    logic signed [W-1:0]  e [9];
  } pipe_t;

  pipe_t          stage_d [NST];
  pipe_t          stage_q [NST];
  logic [NST-1:0] valid_q;
  logic [NST:0]   stage_en;
  logic           keep_q;

  logic signed [CW-1:0] cordic_cos, cordic_sin;
  logic signed [W-1:0]  ax [3];

  assign ax[0] = in_i.axis_x;
  assign ax[1] = in_i.axis_y;
  assign ax[2] = in_i.axis_z;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      keep_q <= 1'b0;
    end else if (cfg_we_i) begin
      keep_q <= cfg_data_i;
    end
  end

  // per-stage advance: empty stages always load
  always_comb begin
    stage_en[NST] = out_o.ready;
    for (int k = NST - 1; k >= 0; k--) begin
      stage_en[k] = !valid_q[k] || stage_en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (stage_en[0]) begin
        valid_q[0] <= in_i.valid;
      end
      for (int k = 1; k < NST; k++) begin
        if (stage_en[k]) begin
          valid_q[k] <= valid_q[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NST; k++) begin
      if (stage_en[k]) begin
        stage_q[k] <= stage_d[k];
      end
    end
  end

  // sin/cos, aligned with the square root stages
  aarm_cordic #(
    .STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk_i (clk_i),
    .en_i  (stage_en[ST_RT0 +: CORDIC_STEPS]),
    .z_i   (stage_q[ST_SUM].z),
    .cos_o (cordic_cos),
    .sin_o (cordic_sin)
  );

  for (genvar k = 0; k < NST; k++) begin : g_stage
    if (k == ST_IN) begin : g_in
      // magnitudes, zero-axis substitution, angle folding
      always_comb begin
        logic [15:0] eff;
        logic [W:0]  sx;
        logic        zero;
        stage_d[k] = '{default: '0};
        zero = (ax[0] == '0) && (ax[1] == '0) && (ax[2] == '0);
        for (int j = 0; j < 3; j++) begin
          sx = {ax[j][W-1], ax[j]};
          stage_d[k].neg[j] = ax[j][W-1];
          stage_d[k].mag[j] = ax[j][W-1] ? (~sx + 1'b1) : sx;
        end
        if (zero) begin
          stage_d[k].mag[2] = (W+1)'(ONE_Q12);
        end
        eff = keep_q ? in_i.turn_angle : (~in_i.turn_angle + 16'd1);
        stage_d[k].flip = eff[15] ^ eff[14];
        if (eff[15] ^ eff[14]) begin
          eff = eff ^ 16'h8000;
        end
        stage_d[k].z = $signed({{2{eff[15]}}, eff, 16'h0000});
      end
    end else if (k == ST_NORM) begin : g_norm
      // scale so the largest magnitude lands in [2^14, 2^15)
      always_comb begin
        logic [W:0]    mx;
        logic [5:0]    p;
        logic [W+15:0] wide;
        stage_d[k] = stage_q[k-1];
        mx = stage_q[k-1].mag[0];
        if (stage_q[k-1].mag[1] > mx) mx = stage_q[k-1].mag[1];
        if (stage_q[k-1].mag[2] > mx) mx = stage_q[k-1].mag[2];
        p = '0;
        for (int i = 0; i <= W; i++) begin
          if (mx[i]) p = 6'(i);
        end
        for (int j = 0; j < 3; j++) begin
          wide = (W+16)'(stage_q[k-1].mag[j]);
          if (p >= 6'd14) begin
            wide = wide >> (p - 6'd14);
          end else begin
            wide = wide << (6'd14 - p);
          end
          stage_d[k].m[j] = wide[14:0];
        end
      end
    end else if (k == ST_SQ) begin : g_sq
      always_comb begin
        stage_d[k] = stage_q[k-1];
        for (int j = 0; j < 3; j++) begin
          stage_d[k].sq[j] = 30'(stage_q[k-1].m[j]) * 30'(stage_q[k-1].m[j]);
        end
      end
    end else if (k == ST_SUM) begin : g_sum
      always_comb begin
        stage_d[k] = stage_q[k-1];
        stage_d[k].v = (62'(stage_q[k-1].sq[0]) + 62'(stage_q[k-1].sq[1])
                      + 62'(stage_q[k-1].sq[2])) << 28;
        stage_d[k].res = '0;
      end
    end else if (k >= ST_RT0 && k <= ST_RT_LAST) begin : g_root
      // one result bit of the square root per stage
      localparam int B = ST_RT_LAST - k;
      always_comb begin
        logic [61:0] trial;
        stage_d[k] = stage_q[k-1];
        trial = stage_q[k-1].res + (62'(1) << (2 * B));
        if (stage_q[k-1].v >= trial) begin
          stage_d[k].v   = stage_q[k-1].v - trial;
          stage_d[k].res = (stage_q[k-1].res >> 1) + (62'(1) << (2 * B));
        end else begin
          stage_d[k].res = stage_q[k-1].res >> 1;
        end
        if (k == ST_CS) begin
          stage_d[k].c = cordic_cos;
          stage_d[k].s = cordic_sin;
        end
      end
    end else if (k == ST_NUM) begin : g_num
      // rounding numerators m*2^28 + r/2
      always_comb begin
        stage_d[k] = stage_q[k-1];
        for (int j = 0; j < 3; j++) begin
          stage_d[k].rem[j] = (44'(stage_q[k-1].m[j]) << 28)
                            + 44'(stage_q[k-1].res[30:1]);
          stage_d[k].q[j] = '0;
        end
      end
    end else if (k >= ST_DV0 && k <= ST_DV_LAST) begin : g_div
      // one quotient bit per stage, three lanes
      localparam int I = ST_DV_LAST - k;
      always_comb begin
        logic [46:0] dd;
        stage_d[k] = stage_q[k-1];
        dd = 47'(stage_q[k-1].res[30:0]) << I;
        for (int j = 0; j < 3; j++) begin
          if (47'(stage_q[k-1].rem[j]) >= dd) begin
            stage_d[k].rem[j] = stage_q[k-1].rem[j] - dd[43:0];
            stage_d[k].q[j][I] = 1'b1;
          end
        end
      end
    end else if (k == ST_U) begin : g_unit
      // clamp, restore sign, apply half-turn fold
      always_comb begin
        logic [15:0] qc;
        stage_d[k] = stage_q[k-1];
        for (int j = 0; j < 3; j++) begin
          qc = (stage_q[k-1].q[j] > UNIT_Q14) ? UNIT_Q14 : stage_q[k-1].q[j];
          stage_d[k].u[j] = stage_q[k-1].neg[j] ? $signed(~qc + 16'd1) : $signed(qc);
        end
        if (stage_q[k-1].flip) begin
          stage_d[k].c = -stage_q[k-1].c;
          stage_d[k].s = -stage_q[k-1].s;
        end
        stage_d[k].t = ONE_Q30 - stage_d[k].c;
      end
    end else if (k == ST_P1) begin : g_p1
      always_comb begin
        stage_d[k] = stage_q[k-1];
        stage_d[k].pr[0] = stage_q[k-1].u[0] * stage_q[k-1].u[0];
        stage_d[k].pr[1] = stage_q[k-1].u[1] * stage_q[k-1].u[1];
        stage_d[k].pr[2] = stage_q[k-1].u[2] * stage_q[k-1].u[2];
        stage_d[k].pr[3] = stage_q[k-1].u[0] * stage_q[k-1].u[1];
        stage_d[k].pr[4] = stage_q[k-1].u[0] * stage_q[k-1].u[2];
        stage_d[k].pr[5] = stage_q[k-1].u[1] * stage_q[k-1].u[2];
      end
    end else if (k == ST_P2) begin : g_p2
      always_comb begin
        stage_d[k] = stage_q[k-1];
        for (int i = 0; i < 6; i++) begin
          stage_d[k].tp[i] = stage_q[k-1].t * stage_q[k-1].pr[i];
        end
        for (int j = 0; j < 3; j++) begin
          stage_d[k].sp[j] = (stage_q[k-1].s * stage_q[k-1].u[j]) <<< 14;
        end
        stage_d[k].ct = 64'(stage_q[k-1].c) <<< 28;
      end
    end else begin : g_out
      // sum, round half up, saturate
      always_comb begin
        logic signed [63:0] sum [9];
        logic signed [63:0] rnd;
        stage_d[k] = stage_q[k-1];
        sum[0] = stage_q[k-1].tp[0] + stage_q[k-1].ct;
        sum[1] = stage_q[k-1].tp[3] + stage_q[k-1].sp[2];
        sum[2] = stage_q[k-1].tp[4] - stage_q[k-1].sp[1];
        sum[3] = stage_q[k-1].tp[3] - stage_q[k-1].sp[2];
        sum[4] = stage_q[k-1].tp[1] + stage_q[k-1].ct;
        sum[5] = stage_q[k-1].tp[5] + stage_q[k-1].sp[0];
        sum[6] = stage_q[k-1].tp[4] + stage_q[k-1].sp[1];
        sum[7] = stage_q[k-1].tp[5] - stage_q[k-1].sp[0];
        sum[8] = stage_q[k-1].tp[2] + stage_q[k-1].ct;
        for (int i = 0; i < 9; i++) begin
          rnd = (sum[i] + RND_HALF) >>> 44;
          if (rnd < SAT_LO) rnd = SAT_LO;
          if (rnd > SAT_HI) rnd = SAT_HI;
          stage_d[k].e[i] = rnd[W-1:0];
        end
      end
    end
  end

  assign in_i.ready   = stage_en[0];
  assign out_o.valid  = valid_q[ST_OUT];
  assign out_o.e_r0c0 = stage_q[ST_OUT].e[0];
  assign out_o.e_r0c1 = stage_q[ST_OUT].e[1];
  assign out_o.e_r0c2 = stage_q[ST_OUT].e[2];
  assign out_o.e_r1c0 = stage_q[ST_OUT].e[3];
  assign out_o.e_r1c1 = stage_q[ST_OUT].e[4];
  assign out_o.e_r1c2 = stage_q[ST_OUT].e[5];
  assign out_o.e_r2c0 = stage_q[ST_OUT].e[6];
  assign out_o.e_r2c1 = stage_q[ST_OUT].e[7];
  assign out_o.e_r2c2 = stage_q[ST_OUT].e[8];

`ifndef SYNTHESIS
  // an empty output stage means the whole chain can advance
  a_ready_when_out_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !valid_q[ST_OUT] |-> in_i.ready)
    else $error("input stalled with empty output stage");

  // normalized axis scaling keeps the root in [2^28, 2^31)
  a_root_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[ST_NUM] |-> (stage_q[ST_NUM].res >= 62'(1 << 28))
                     && (stage_q[ST_NUM].res < (62'(1) << 31)))
    else $error("square root out of range");

  // unit components stay within one
  a_unit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[ST_U] |-> (stage_q[ST_U].u[0] <= 16'sd16384)
                   && (stage_q[ST_U].u[0] >= -16'sd16384)
                   && (stage_q[ST_U].u[1] <= 16'sd16384)
                   && (stage_q[ST_U].u[1] >= -16'sd16384)
                   && (stage_q[ST_U].u[2] <= 16'sd16384)
                   && (stage_q[ST_U].u[2] >= -16'sd16384))
    else $error("unit component out of range");
`endif

endmodule
